FILE: design/h264lp_pkg.sv
// ----------------------------------------------------------------------------
// h264lp_pkg
// Shared types and constants for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
`default_nettype none

package h264lp_pkg;

    localparam int unsigned PARAM_BYTES_DEF     = 56;
    localparam int unsigned PACKET_LEN_BITS_DEF = 24;

    // Address width of the store write port; covers every legal store depth.
    localparam int unsigned STORE_AW    = 6;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;

    localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
    localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FRAMING   = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic CMD_EXTRA  = 1'b0;
    localparam logic CMD_PACKET = 1'b1;

    localparam logic [2:0] SC_NONE  = 3'd0;
    localparam logic [2:0] SC_SHORT = 3'd3;
    localparam logic [2:0] SC_LONG  = 3'd4;

    // One unit of work for the output sequencer.
    typedef struct packed {
        logic       ins_params;  // emit stored parameter set first
        logic [2:0] sc_len;      // start code length: none, 3 or 4
        logic       tail;        // a final data or status result follows
        logic       tail_byte;   // tail carries a data byte
        logic [7:0] data;
        logic [1:0] status;
    } t_job;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_store_wr;

endpackage : h264lp_pkg

`default_nettype wire

FILE: design/h264lp_front.sv
// ----------------------------------------------------------------------------
// h264lp_front
// Parses extradata and packet bytes, fills the parameter store and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module h264lp_front #(
    parameter int unsigned PARAM_BYTES     = h264lp_pkg::PARAM_BYTES_DEF,
    parameter int unsigned PACKET_LEN_BITS = h264lp_pkg::PACKET_LEN_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic                   i_command,
    input  wire logic [7:0]             i_data_byte,
    input  wire logic                   i_last,
    input  wire logic [23:0]            i_packet_length,
    input  wire logic                   i_back_idle,
    input  wire logic                   i_q_full,
    output logic                        o_push,
    output h264lp_pkg::t_job            o_job,
    output h264lp_pkg::t_store_wr       o_wr,
    output logic [$clog2(PARAM_BYTES+1)-1:0] o_param_fill
);
    import h264lp_pkg::*;

    localparam int unsigned FILL_W = $clog2(PARAM_BYTES + 1);
    localparam int unsigned PLB    = PACKET_LEN_BITS;

    typedef enum logic [7:0] {
        PH_HDR    = 8'b0000_0001,
        PH_SPS_N  = 8'b0000_0010,
        PH_LEN_HI = 8'b0000_0100,
        PH_LEN_LO = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_PPS_N  = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_ERR    = 8'b1000_0000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [15:0]        r_count, n_count;
    logic [7:0]         r_units, n_units;
    logic               r_pps, n_pps;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic               r_ok, n_ok;
    logic [1:0]         r_sc_left, n_sc_left;

    logic [PLB-1:0]     r_pkt_left, n_pkt_left;
    logic [1:0]         r_pfx, n_pfx;
    logic [31:0]        r_nal_len, n_nal_len;
    logic [31:0]        r_nal_left, n_nal_left;
    logic               r_first, n_first;
    logic               r_drop, n_drop;

    logic               accept;
    logic [17:0]        need;
    logic [15:0]        len_word;
    logic [PLB-1:0]     plen;

    assign o_ready = !i_q_full && (r_sc_left == 2'd0)
                   && ((i_command == CMD_PACKET) || i_back_idle);
    assign accept       = i_valid && o_ready;
    assign o_param_fill = r_fill;
    assign plen         = PLB'(i_packet_length);
    assign len_word     = {r_count[15:8], i_data_byte};
    assign need         = 18'(r_fill) + 18'd4 + 18'(len_word);

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_units    = r_units;
        n_pps      = r_pps;
        n_fill     = r_fill;
        n_ok       = r_ok;
        n_sc_left  = r_sc_left;
        n_pkt_left = r_pkt_left;
        n_pfx      = r_pfx;
        n_nal_len  = r_nal_len;
        n_nal_left = r_nal_left;
        n_first    = r_first;
        n_drop     = r_drop;
        o_push     = 1'b0;
        o_job      = '0;
        o_wr       = '0;

        if (r_sc_left != 2'd0) begin
            // Remaining start-code bytes of a stored unit, one per cycle.
            o_wr.en   = 1'b1;
            o_wr.addr = STORE_AW'(r_fill);
            o_wr.data = (r_sc_left == 2'd1) ? 8'd1 : 8'd0;
            n_fill    = r_fill + FILL_W'(1);
            n_sc_left = r_sc_left - 2'd1;
        end else if (accept && i_command == CMD_EXTRA) begin
            if (r_phase == PH_HDR && r_count == 16'd0) begin
                n_fill  = '0;
                n_ok    = 1'b0;
                n_units = '0;
                n_pps   = 1'b0;
            end
            unique case (r_phase)
                PH_HDR: begin
                    n_count = r_count + 16'd1;
                    if (n_count >= 16'd5) begin
                        n_phase = PH_SPS_N;
                    end
                end
                PH_SPS_N: begin
                    n_units = {3'd0, i_data_byte[4:0]};
                    n_pps   = 1'b0;
                    n_phase = (i_data_byte[4:0] != 5'd0) ? PH_LEN_HI : PH_PPS_N;
                end
                PH_LEN_HI: begin
                    n_count = {i_data_byte, 8'd0};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_count = len_word;
                    if (need > 18'(PARAM_BYTES)) begin
                        n_ok    = 1'b0;
                        n_phase = PH_ERR;
                        o_push  = 1'b1;
                        o_job.tail   = 1'b1;
                        o_job.status = ST_OVERFLOW;
                    end else begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = STORE_AW'(r_fill);
                        o_wr.data = 8'd0;
                        n_fill    = r_fill + FILL_W'(1);
                        n_sc_left = 2'd3;
                        if (len_word == 16'd0) begin
                            n_units = r_units - 8'd1;
                            if (n_units != 8'd0) begin
                                n_phase = PH_LEN_HI;
                            end else if (r_pps) begin
                                n_phase = PH_DONE;
                                n_ok    = 1'b1;
                            end else begin
                                n_phase = PH_PPS_N;
                            end
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    if (32'(r_fill) < PARAM_BYTES) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = STORE_AW'(r_fill);
                        o_wr.data = i_data_byte;
                        n_fill    = r_fill + FILL_W'(1);
                    end
                    n_count = r_count - 16'd1;
                    if (n_count == 16'd0) begin
                        n_units = r_units - 8'd1;
                        if (n_units != 8'd0) begin
                            n_phase = PH_LEN_HI;
                        end else if (r_pps) begin
                            n_phase = PH_DONE;
                            n_ok    = 1'b1;
                        end else begin
                            n_phase = PH_PPS_N;
                        end
                    end
                end
                PH_PPS_N: begin
                    n_units = i_data_byte;
                    n_pps   = 1'b1;
                    if (i_data_byte == 8'd0) begin
                        n_phase = PH_DONE;
                        n_ok    = 1'b1;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_DONE, PH_ERR: begin
                end
                default: begin
                end
            endcase
            if (i_last) begin
                if (n_phase != PH_DONE && n_phase != PH_ERR && !o_push) begin
                    n_ok   = 1'b0;
                    o_push = 1'b1;
                    o_job.tail   = 1'b1;
                    o_job.status = ST_TRUNCATED;
                end
                n_phase = PH_HDR;
                n_count = '0;
            end
        end else if (accept) begin
            logic [PLB-1:0] pl;
            logic [1:0]     pfx;
            logic [31:0]    nlen;
            logic [31:0]    nleft;
            logic           first;
            logic           drop;
            pl    = r_pkt_left;
            pfx   = r_pfx;
            nlen  = r_nal_len;
            nleft = r_nal_left;
            first = r_first;
            drop  = r_drop;
            if (r_pkt_left == '0) begin
                // A zero length still makes a packet of one byte.
                pl    = (plen == '0) ? PLB'(1) : plen;
                pfx   = '0;
                nlen  = '0;
                nleft = '0;
                first = 1'b1;
                drop  = 1'b0;
            end
            if (!drop) begin
                if (nleft != 32'd0) begin
                    o_push         = 1'b1;
                    o_job.tail     = 1'b1;
                    o_job.tail_byte = 1'b1;
                    o_job.data     = i_data_byte;
                    if (nleft == nlen) begin
                        o_job.ins_params = r_ok
                            && ((i_data_byte & NAL_TYPE_MASK) == 8'(NAL_TYPE_IDR));
                        o_job.sc_len = first ? SC_LONG : SC_SHORT;
                        first = 1'b0;
                    end
                    nleft = nleft - 32'd1;
                end else if (pfx == 2'd0 && 32'(pl) < 32'd4) begin
                    drop   = 1'b1;
                    o_push = 1'b1;
                    o_job.tail   = 1'b1;
                    o_job.status = ST_FRAMING;
                end else begin
                    nlen = (pfx == 2'd0) ? {24'd0, i_data_byte}
                                         : {nlen[23:0], i_data_byte};
                    if (pfx == 2'd3) begin
                        if (nlen > 32'(pl - PLB'(1))) begin
                            drop   = 1'b1;
                            o_push = 1'b1;
                            o_job.tail   = 1'b1;
                            o_job.status = ST_FRAMING;
                        end else begin
                            nleft = nlen;
                            if (nlen == 32'd0) begin
                                o_push       = 1'b1;
                                o_job.sc_len = first ? SC_LONG : SC_SHORT;
                                first        = 1'b0;
                            end
                        end
                    end
                    pfx = pfx + 2'd1;
                end
            end
            pl = pl - PLB'(1);
            if (pl == '0) begin
                pfx   = '0;
                nleft = '0;
                first = 1'b1;
                drop  = 1'b0;
            end
            n_pkt_left = pl;
            n_pfx      = pfx;
            n_nal_len  = nlen;
            n_nal_left = nleft;
            n_first    = first;
            n_drop     = drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR;
            r_count    <= '0;
            r_units    <= '0;
            r_pps      <= 1'b0;
            r_fill     <= '0;
            r_ok       <= 1'b0;
            r_sc_left  <= '0;
            r_pkt_left <= '0;
            r_pfx      <= '0;
            r_nal_len  <= '0;
            r_nal_left <= '0;
            r_first    <= 1'b1;
            r_drop     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_units    <= n_units;
            r_pps      <= n_pps;
            r_fill     <= n_fill;
            r_ok       <= n_ok;
            r_sc_left  <= n_sc_left;
            r_pkt_left <= n_pkt_left;
            r_pfx      <= n_pfx;
            r_nal_len  <= n_nal_len;
            r_nal_left <= n_nal_left;
            r_first    <= n_first;
            r_drop     <= n_drop;
        end
    end

endmodule : h264lp_front

`default_nettype wire

FILE: design/h264lp_queue.sv
// ----------------------------------------------------------------------------
// h264lp_queue
// Small job FIFO between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module h264lp_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  h264lp_pkg::t_job       i_job,
    input  wire logic              i_pop,
    output h264lp_pkg::t_job       o_head,
    output logic                   o_empty,
    output logic                   o_full
);
    import h264lp_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + (QUEUE_AW + 1)'(i_push) - (QUEUE_AW + 1)'(i_pop);
        end
    end

endmodule : h264lp_queue

`default_nettype wire

FILE: design/h264lp_back.sv
// ----------------------------------------------------------------------------
// h264lp_back
// Holds the parameter store and expands jobs into output results.
// ----------------------------------------------------------------------------
`default_nettype none

module h264lp_back #(
    parameter int unsigned PARAM_BYTES = h264lp_pkg::PARAM_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  h264lp_pkg::t_store_wr            i_wr,
    input  wire logic [$clog2(PARAM_BYTES+1)-1:0] i_param_fill,
    input  h264lp_pkg::t_job                 i_head,
    input  wire logic                        i_empty,
    output logic                             o_pop,
    output logic                             o_idle,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_byte_valid,
    output logic [1:0]                       o_status,
    output logic                             o_run_end
);
    import h264lp_pkg::*;

    localparam int unsigned FILL_W = $clog2(PARAM_BYTES + 1);
    localparam int unsigned IDX_W  = $clog2(PARAM_BYTES);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PARAM = 4'b0010,
        S_START = 4'b0100,
        S_TAIL  = 4'b1000
    } t_seq;

    logic [7:0]        r_store [PARAM_BYTES];
    logic [7:0]        r_rd;

    t_seq              r_state, n_state;
    t_job              r_job, n_job;
    logic [FILL_W-1:0] r_cnt, n_cnt;

    logic       r_s1_v, r_s1_mem, r_s1_bv, r_s1_last;
    logic [7:0] r_s1_byte;
    logic [1:0] r_s1_st;

    logic       r_o_v, r_o_bv, r_o_last;
    logic [7:0] r_o_byte;
    logic [1:0] r_o_st;

    logic       adv_out, s1_free, emit;
    logic       sl_mem, sl_bv, sl_last, sl_phase_end;
    logic [7:0] sl_byte;
    logic [1:0] sl_st;
    t_seq       head_first;

    assign adv_out = !r_o_v || i_ready;
    assign s1_free = !r_s1_v || adv_out;
    assign emit    = s1_free && (r_state != S_IDLE);
    assign o_idle  = (r_state == S_IDLE);

    always_comb begin
        if (i_head.ins_params && i_param_fill != '0) begin
            head_first = S_PARAM;
        end else if (i_head.sc_len != SC_NONE) begin
            head_first = S_START;
        end else begin
            head_first = S_TAIL;
        end
    end

    // Result produced by the sequencer in its current step.
    always_comb begin
        sl_mem       = 1'b0;
        sl_bv        = 1'b1;
        sl_byte      = 8'd0;
        sl_st        = ST_OK;
        sl_last      = 1'b0;
        sl_phase_end = 1'b0;
        unique case (r_state)
            S_PARAM: begin
                sl_mem       = 1'b1;
                sl_phase_end = (r_cnt == i_param_fill - FILL_W'(1));
            end
            S_START: begin
                sl_phase_end = (r_cnt == FILL_W'(r_job.sc_len) - FILL_W'(1));
                sl_byte      = sl_phase_end ? 8'd1 : 8'd0;
                sl_last      = sl_phase_end && !r_job.tail;
            end
            S_TAIL: begin
                sl_phase_end = 1'b1;
                sl_bv        = r_job.tail_byte;
                sl_byte      = r_job.tail_byte ? r_job.data : 8'd0;
                sl_st        = r_job.status;
                sl_last      = 1'b1;
            end
            S_IDLE: begin
                sl_bv = 1'b0;
            end
            default: begin
                sl_bv = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_cnt   = r_cnt;
        o_pop   = 1'b0;
        if (r_state == S_IDLE || (emit && sl_last)) begin
            if (!i_empty) begin
                o_pop   = 1'b1;
                n_job   = i_head;
                n_state = head_first;
                n_cnt   = '0;
            end else begin
                n_state = S_IDLE;
            end
        end else if (emit) begin
            if (sl_phase_end) begin
                n_cnt   = '0;
                n_state = (r_state == S_PARAM) ? S_START : S_TAIL;
            end else begin
                n_cnt = r_cnt + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[i_wr.addr[IDX_W-1:0]] <= i_wr.data;
        end
        if (emit && sl_mem) begin
            r_rd <= r_store[r_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_mem  <= sl_mem;
            r_s1_bv   <= sl_bv;
            r_s1_byte <= sl_byte;
            r_s1_st   <= sl_st;
            r_s1_last <= sl_last;
        end
        if (adv_out && r_s1_v) begin
            r_o_byte <= r_s1_mem ? r_rd : r_s1_byte;
            r_o_bv   <= r_s1_bv;
            r_o_st   <= r_s1_st;
            r_o_last <= r_s1_last;
        end
        r_job <= n_job;
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_s1_v  <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s1_free) begin
                r_s1_v <= emit;
            end
            if (adv_out) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    assign o_valid      = r_o_v;
    assign o_out_byte   = r_o_byte;
    assign o_byte_valid = r_o_bv;
    assign o_status     = r_o_st;
    assign o_run_end    = r_o_last;

    a_param_needs_idr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PARAM |-> r_job.ins_params && r_job.sc_len != SC_NONE)
        else $error("parameter set emitted for a job without a start code");

    a_start_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_START |-> r_cnt < FILL_W'(r_job.sc_len))
        else $error("start code counter out of range");

    a_status_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_v && !r_o_bv |-> r_o_last && r_o_byte == 8'd0)
        else $error("status-only result not marked as the end of its run");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty && (r_state == S_IDLE || emit))
        else $error("job popped while the sequencer was busy");

endmodule : h264lp_back

`default_nettype wire

FILE: design/h264_length_prefix_to_start_code_core.sv
// ----------------------------------------------------------------------------
// h264_length_prefix_to_start_code_core
// Converts avcC extradata and length-prefixed H.264 packets to Annex-B bytes.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                       tuser                   tlast
//  s_axis    in         [7:0] data_byte,            [0] command             last
//                       [31:8] packet_length
//  m_axis    out        [7:0] out_byte              [0] byte_valid,         run_end
//                                                   [2:1] status
//
// A packet byte is taken while the job queue has room; the first byte of a unit
// adds its start code, and that of an IDR unit also the stored parameter set,
// as extra results on the single output port.
// Input is held off while the rest of a stored unit's start code is written.
// Extradata bytes wait until the job queue is empty and the sequencer is idle.
// Reset is synchronous and active low; the store content is not cleared.
// Output stalls back up through the job queue to the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_length_prefix_to_start_code_core #(
    parameter int unsigned PARAM_BYTES     = h264lp_pkg::PARAM_BYTES_DEF,
    parameter int unsigned PACKET_LEN_BITS = h264lp_pkg::PACKET_LEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // data_byte, packet_length
    input  wire logic [0:0]  i_s_axis_tuser,   // command
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // out_byte
    output logic [2:0]       o_m_axis_tuser,   // byte_valid, status
    output logic             o_m_axis_tlast
);
    import h264lp_pkg::*;

    localparam int unsigned FILL_W = $clog2(PARAM_BYTES + 1);

    t_job              push_job, head_job;
    t_store_wr         store_wr;
    logic              push, pop, q_empty, q_full, back_idle, byte_valid;
    logic [1:0]        status;
    logic [FILL_W-1:0] param_fill;

    h264lp_front #(
        .PARAM_BYTES     (PARAM_BYTES),
        .PACKET_LEN_BITS (PACKET_LEN_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_command       (i_s_axis_tuser[0]),
        .i_data_byte     (i_s_axis_tdata[7:0]),
        .i_last          (i_s_axis_tlast),
        .i_packet_length (i_s_axis_tdata[31:8]),
        .i_back_idle     (back_idle && q_empty),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_job           (push_job),
        .o_wr            (store_wr),
        .o_param_fill    (param_fill)
    );

    h264lp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    h264lp_back #(
        .PARAM_BYTES (PARAM_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (store_wr),
        .i_param_fill (param_fill),
        .i_head       (head_job),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_idle       (back_idle),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_out_byte   (o_m_axis_tdata),
        .o_byte_valid (byte_valid),
        .o_status     (status),
        .o_run_end    (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {status, byte_valid};

endmodule : h264_length_prefix_to_start_code_core

`default_nettype wire
